>>> rtl/gb2312_glyph_address_parser_defines.svh
// assertion macros for the glyph address parser
`ifndef GB2312_GLYPH_ADDRESS_PARSER_DEFINES_SVH
`define GB2312_GLYPH_ADDRESS_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define G2GAP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph parser check failed");
`define G2GAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph parser check failed");
`else
`define G2GAP_ASSERT_IMPL(label, ante, cons)
`define G2GAP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/g2gap_pkg.sv
package g2gap_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AddrW = 18;
	localparam int unsigned ColW = 8;
	localparam int unsigned CellW = AddrW - 5;
	localparam int unsigned OutDataW = ((AddrW + ColW + 7) / 8) * 8;

	localparam logic [ByteW-1:0] EndByte = 8'h00;
	localparam logic [ByteW-1:0] HanziLeadLo = 8'hB0;
	localparam logic [ByteW-1:0] HanziLeadHi = 8'hF7;
	localparam logic [ByteW-1:0] SymbolLeadLo = 8'hA1;
	localparam logic [ByteW-1:0] SymbolLeadHi = 8'hA3;
	localparam logic [ByteW-1:0] TrailLo = 8'hA1;
	localparam logic [ByteW-1:0] AsciiLo = 8'h20;
	localparam logic [ByteW-1:0] AsciiHi = 8'h7E;

	localparam logic [CellW-1:0] RowCells = 13'd94;
	localparam logic [CellW-1:0] HanziCellBase = 13'd846;
	localparam logic [AddrW-1:0] AsciiBase = 18'h3CF80;

	localparam logic [ColW-1:0] WideStep = 8'd16;
	localparam logic [ColW-1:0] NarrowStep = 8'd8;
	localparam logic [ColW-1:0] StartColumnReset = 8'd1;

	typedef struct packed {
		logic end_string;
		logic emit;
		logic wide;
		logic [AddrW-1:0] addr;
		logic lead_next;
	} g2gap_dec_t;

endpackage

>>> rtl/g2gap_decode.sv
module g2gap_decode
	import g2gap_pkg::*;
(
	input  logic [ByteW-1:0] text_byte,
	input  logic             lead_pending,
	input  logic [ByteW-1:0] lead_byte,
	output g2gap_dec_t       dec
);

	logic             is_end;
	logic             pair;
	logic             is_lead;
	logic             is_ascii;
	logic             hanzi;
	logic [6:0]       row;
	logic [CellW-1:0] row_cells;
	logic [CellW-1:0] glyph_idx;
	logic [ByteW-1:0] trail_off;
	logic [ByteW-1:0] ascii_off;
	logic [AddrW-1:0] wide_addr;
	logic [AddrW-1:0] narrow_addr;

	always_comb begin
		is_end = (text_byte == EndByte);
		pair = lead_pending && (text_byte >= TrailLo);
		is_lead = ((text_byte >= HanziLeadLo) && (text_byte <= HanziLeadHi)) ||
			((text_byte >= SymbolLeadLo) && (text_byte <= SymbolLeadHi));
		is_ascii = (text_byte >= AsciiLo) && (text_byte <= AsciiHi);

		hanzi = (lead_byte >= HanziLeadLo);
		row = hanzi ? 7'(lead_byte - HanziLeadLo) : 7'(lead_byte - SymbolLeadLo);
		row_cells = CellW'(row) * RowCells;
		trail_off = text_byte - TrailLo;
		glyph_idx = row_cells + CellW'(trail_off) + (hanzi ? HanziCellBase : '0);
		wide_addr = {glyph_idx, 5'b0};

		ascii_off = text_byte - AsciiLo;
		narrow_addr = AddrW'({ascii_off[6:0], 4'b0}) + AsciiBase;

		dec.end_string = is_end;
		dec.emit = !is_end && (pair || (!is_lead && is_ascii));
		dec.wide = pair;
		dec.addr = pair ? wide_addr : narrow_addr;
		dec.lead_next = !is_end && !pair && is_lead;
	end

endmodule

>>> rtl/gb2312_glyph_address_parser.sv
// 2 register stages: the input register, then the result register, which takes a decoded byte only while free
// throughput: one text byte per cycle, sustained while the result side takes requests
// a lead byte, the column and the start column carry over between bytes, all in registers
// reset: no held lead, column and start column at 1, both register stages empty
`include "gb2312_glyph_address_parser_defines.svh"

module gb2312_glyph_address_parser
	import g2gap_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [ColW-1:0]     cfg_wr_data,  // start_column
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteW-1:0]    s_tdata,      // text_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,      // font_address, glyph_column, zero fill
	output logic                m_tuser       // wide_glyph
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             valid_s2;
	logic [AddrW-1:0] addr_s2;
	logic             wide_s2;
	logic [ColW-1:0]  col_s2;

	logic [ColW-1:0]  start_col_q;
	logic [ColW-1:0]  col_q;
	logic [ByteW-1:0] lead_q;
	logic             lead_pending_q;

	logic             out_free;
	logic             adv_s1;
	g2gap_dec_t       dec;

	assign out_free = !valid_s2 || m_tready;
	assign adv_s1 = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	g2gap_decode u_decode (
		.text_byte    (byte_s1),
		.lead_pending (lead_pending_q),
		.lead_byte    (lead_q),
		.dec          (dec)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q <= StartColumnReset;
			col_q <= StartColumnReset;
			lead_q <= '0;
			lead_pending_q <= 1'b0;
		end else if (cfg_wr_en) begin
			start_col_q <= cfg_wr_data;
			col_q <= cfg_wr_data;
			lead_q <= '0;
			lead_pending_q <= 1'b0;
		end else if (adv_s1) begin
			lead_pending_q <= dec.lead_next;
			lead_q <= dec.lead_next ? byte_s1 : '0;
			if (dec.end_string) begin
				col_q <= start_col_q;
			end else if (dec.emit) begin
				col_q <= col_q + (dec.wide ? WideStep : NarrowStep);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dec.emit) begin
			addr_s2 <= dec.addr;
			wide_s2 <= dec.wide;
			col_s2 <= col_q;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = wide_s2;
	assign m_tdata = {(OutDataW - AddrW - ColW)'(0), col_s2, addr_s2};

	`G2GAP_ASSERT_IMPL(a_lead_range, lead_pending_q,
		((lead_q >= HanziLeadLo) && (lead_q <= HanziLeadHi)) ||
		((lead_q >= SymbolLeadLo) && (lead_q <= SymbolLeadHi)))
	`G2GAP_ASSERT_IMPL(a_wide_region, valid_s2 && wide_s2,
		(addr_s2[4:0] == 5'b0) && (addr_s2 < AsciiBase))
	`G2GAP_ASSERT_IMPL(a_narrow_region, valid_s2 && !wide_s2,
		(addr_s2 >= AsciiBase) && (addr_s2[3:0] == 4'b0))
	`G2GAP_ASSERT_NEXT(a_s1_hold, valid_s1 && !out_free,
		valid_s1 && $stable(byte_s1))

endmodule
